[hw/rtl/plre_pkg.sv]
// shared types and constants for the permutation lehmer range encoder
package plre_pkg;

    localparam int unsigned PERM_W = 17;
    localparam int unsigned VAL_W  = 16;

    localparam logic [31:0] LOW_TOP    = 32'hFF000000;
    localparam logic [31:0] RANGE_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] RANGE_MIN  = 32'h01000000;
    localparam logic [31:0] PEND_MAX   = 32'hFFFFFFFF;
    localparam logic [7:0]  BYTE_FF    = 8'hFF;
    localparam logic [2:0]  FLUSH_SHIFTS = 3'd5;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_RANGE   = 2'd1,
        ST_REUSED  = 2'd2,
        ST_SURPLUS = 2'd3
    } status_t;

    typedef enum logic {
        ACT_CODE  = 1'b0,
        ACT_FLUSH = 1'b1
    } act_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  head;
        logic [31:0] run_len;
        logic [7:0]  run_byte;
    } res_t;

    typedef enum logic [1:0] {
        RC_NONE   = 2'd0,
        RC_QUERY  = 2'd1,
        RC_UPDATE = 2'd2,
        RC_CLEAR  = 2'd3
    } rank_cmd_t;

    typedef struct packed {
        rank_cmd_t          cmd;
        logic [VAL_W-1:0]   value;
    } rank_req_t;

    typedef struct packed {
        logic              busy;
        logic              used;
        logic [PERM_W-1:0] count;
    } rank_sts_t;

endpackage

[hw/rtl/plre_div.sv]
// iterative restoring divider, one quotient bit per cycle
module plre_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 dividend,
    input  logic [plre_pkg::PERM_W-1:0] divisor,
    output logic                        busy,
    output logic [31:0]                 quotient
);

    logic                        busy_reg, busy_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [31:0]                 quo_reg, quo_next;
    logic [plre_pkg::PERM_W-1:0] rem_reg, rem_next;
    logic [plre_pkg::PERM_W-1:0] div_reg, div_next;
    logic [plre_pkg::PERM_W:0]   rem_sh;
    logic                        ge;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], ge};
            rem_next = ge ? plre_pkg::PERM_W'(rem_sh - {1'b0, div_reg})
                          : rem_sh[plre_pkg::PERM_W-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/plre_rank.sv]
// used-value set: fenwick tree of used counts plus a used-flag memory
module plre_rank #(
    parameter int unsigned DEPTH = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  plre_pkg::rank_req_t  req,
    output plre_pkg::rank_sts_t  sts
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IW = AW + 2;
    localparam int unsigned CW = AW + 1;
    localparam logic [IW-1:0] DEPTH_IX = IW'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [6:0] {
        R_CLR   = 7'b0000001,
        R_IDLE  = 7'b0000010,
        R_QWAIT = 7'b0000100,
        R_QRD   = 7'b0001000,
        R_QACC  = 7'b0010000,
        R_URD   = 7'b0100000,
        R_UWR   = 7'b1000000
    } rstate_t;

    rstate_t         state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   val_reg, val_next;
    logic [CW-1:0]   sum_reg, sum_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   fen_rd_reg;
    logic            used_rd_reg;

    logic [CW-1:0]   fen_mem [DEPTH];
    logic            used_mem [DEPTH];

    logic [IW-1:0]   idx_m1;
    logic [IW-1:0]   lowbit;
    logic            fen_we;
    logic [AW-1:0]   fen_waddr;
    logic [CW-1:0]   fen_wdata;
    logic            used_we;
    logic [AW-1:0]   used_waddr;
    logic            used_wdata;

    assign idx_m1 = idx_reg - IW'(1);
    assign lowbit = idx_reg & (~idx_reg + IW'(1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        sum_next   = sum_reg;
        clr_next   = clr_reg;
        fen_we     = 1'b0;
        fen_waddr  = idx_m1[AW-1:0];
        fen_wdata  = fen_rd_reg + CW'(1);
        used_we    = 1'b0;
        used_waddr = req.value[AW-1:0];
        used_wdata = 1'b1;
        unique case (state_reg)
            R_CLR:
            begin
                fen_we     = 1'b1;
                fen_waddr  = clr_reg;
                fen_wdata  = '0;
                used_we    = 1'b1;
                used_waddr = clr_reg;
                used_wdata = 1'b0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = R_IDLE;
                end
            end
            R_IDLE:
            begin
                unique case (req.cmd)
                    plre_pkg::RC_QUERY:
                    begin
                        val_next   = req.value[AW-1:0];
                        idx_next   = IW'(req.value[AW-1:0]);
                        sum_next   = '0;
                        state_next = R_QWAIT;
                    end
                    plre_pkg::RC_UPDATE:
                    begin
                        val_next   = req.value[AW-1:0];
                        idx_next   = IW'(req.value[AW-1:0]) + IW'(1);
                        used_we    = 1'b1;
                        state_next = R_URD;
                    end
                    plre_pkg::RC_CLEAR:
                    begin
                        clr_next   = '0;
                        state_next = R_CLR;
                    end
                    default:
                    begin
                        state_next = R_IDLE;
                    end
                endcase
            end
            R_QWAIT:
            begin
                state_next = R_QRD;
            end
            R_QRD:
            begin
                state_next = (idx_reg == '0) ? R_IDLE : R_QACC;
            end
            R_QACC:
            begin
                sum_next   = sum_reg + fen_rd_reg;
                idx_next   = idx_reg - lowbit;
                state_next = R_QRD;
            end
            R_URD:
            begin
                state_next = (idx_reg > DEPTH_IX) ? R_IDLE : R_UWR;
            end
            R_UWR:
            begin
                fen_we     = 1'b1;
                idx_next   = idx_reg + lowbit;
                state_next = R_URD;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_CLR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (fen_we)
        begin
            fen_mem[fen_waddr] <= fen_wdata;
        end
        fen_rd_reg <= fen_mem[idx_m1[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rd_reg <= used_mem[val_reg];
    end

    assign sts.busy  = (state_reg != R_IDLE);
    assign sts.used  = used_rd_reg;
    assign sts.count = plre_pkg::PERM_W'(sum_reg);

endmodule

[hw/rtl/permutation_lehmer_range_encoder.sv]
// top level: permutation elements to lehmer digits through a carry-cached range coder
//
// Each element starts a divide of the range by the number of values left, which
// runs beside the fenwick rank walk (one step per set bit of the value, so at most
// one per tree level); then come a multiply, an add, one normalizing shift per byte
// and the fenwick update walk (up to log2 of the set depth plus one levels). A shift
// that emits a byte waits while the output stage is blocked. Out-of-range and surplus
// elements are answered without the divide; a reused value is only seen once the
// divide and the rank walk are done. A flush takes five shifts and then a clearing
// pass over the used set, one entry a cycle (min(MAX_ELEMS, 65536) entries); the
// same pass runs after reset. Input is not taken during that pass; configuration
// writes always are.
module permutation_lehmer_range_encoder #(
    parameter int unsigned MAX_ELEMS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,       // perm_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // elem_value
    input  logic [0:0]  s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // head_byte, run_length, run_byte
    output logic [1:0]  m_axis_tuser,    // status
    output logic        m_axis_tlast
);

    localparam int unsigned SET_DEPTH = (MAX_ELEMS < 65536) ? MAX_ELEMS : 65536;
    localparam int unsigned N_CAP_I   = (MAX_ELEMS > 131071) ? 131071 : MAX_ELEMS;
    localparam logic [16:0] N_CAP     = N_CAP_I[16:0];

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_ADD   = 10'b0000001000,
        S_NORM  = 10'b0000010000,
        S_UPD   = 10'b0000100000,
        S_UPDW  = 10'b0001000000,
        S_FLUSH = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_ERR   = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [16:0]         size_reg, size_next;
    logic [16:0]         eidx_reg, eidx_next;
    logic [32:0]         low_reg, low_next;
    logic [31:0]         range_reg, range_next;
    logic [7:0]          cache_reg, cache_next;
    logic [31:0]         pend_reg, pend_next;
    logic                hold_valid_reg, hold_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                flush_reg, flush_next;
    logic [2:0]          fcnt_reg, fcnt_next;

    plre_pkg::res_t      hold_reg, hold_next;
    plre_pkg::res_t      out_reg, out_next;
    logic                out_last_reg, out_last_next;
    plre_pkg::status_t   err_reg, err_next;
    logic [16:0]         m_reg, m_next;
    logic [15:0]         val_reg, val_next;
    logic [31:0]         prod_reg, prod_next;

    plre_pkg::rank_req_t rank_req;
    plre_pkg::rank_sts_t rank_sts;
    logic                div_start;
    logic                div_busy;
    logic [31:0]         div_quo;

    logic [16:0]         n_eff;
    logic                in_acc;
    logic                out_free;
    logic                carry;
    logic [31:0]         lo32;
    logic                sh_emit;
    plre_pkg::res_t      sh_res;
    logic [7:0]          sh_cache;
    logic [31:0]         sh_pend;
    logic [32:0]         sh_low;
    logic                do_shift;
    logic [15:0]         rank_val;
    logic [47:0]         prod_full;

    plre_rank #(.DEPTH(SET_DEPTH)) u_rank
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rank_req),
        .sts   (rank_sts)
    );

    plre_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (range_reg),
        .divisor  (m_next),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = 17'd1;
        end
        else if (size_reg > N_CAP)
        begin
            n_eff = N_CAP;
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !rank_sts.busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // one low shift: emit cached byte plus carry and the pending run
    assign carry            = low_reg[32];
    assign lo32             = low_reg[31:0];
    assign sh_emit          = carry || (lo32 < plre_pkg::LOW_TOP);
    assign sh_res.status    = plre_pkg::ST_RUN;
    assign sh_res.head      = cache_reg + {7'd0, carry};
    assign sh_res.run_len   = pend_reg - 32'd1;
    assign sh_res.run_byte  = plre_pkg::BYTE_FF + {7'd0, carry};
    assign sh_cache         = sh_emit ? lo32[31:24] : cache_reg;
    assign sh_pend          = sh_emit ? 32'd1
                            : ((pend_reg != plre_pkg::PEND_MAX) ? pend_reg + 32'd1 : pend_reg);
    assign sh_low           = {1'b0, lo32[23:0], 8'h00};
    assign do_shift         = !(sh_emit && hold_valid_reg && !out_free);

    assign rank_val  = val_reg - rank_sts.count[15:0];
    assign prod_full = rank_val * div_quo;

    always_comb
    begin
        state_next      = state_reg;
        size_next       = cfg_we ? cfg_wdata : size_reg;
        eidx_next       = eidx_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        cache_next      = cache_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        flush_next      = flush_reg;
        fcnt_next       = fcnt_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        err_next        = err_reg;
        m_next          = m_reg;
        val_next        = val_reg;
        prod_next       = prod_reg;
        rank_req.cmd    = plre_pkg::RC_NONE;
        rank_req.value  = val_reg;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    val_next = s_axis_tdata;
                    if (plre_pkg::act_t'(s_axis_tuser[0]) == plre_pkg::ACT_FLUSH)
                    begin
                        flush_next = 1'b1;
                        fcnt_next  = '0;
                        state_next = S_FLUSH;
                    end
                    else if (eidx_reg >= n_eff)
                    begin
                        err_next   = plre_pkg::ST_SURPLUS;
                        state_next = S_ERR;
                    end
                    else if ({1'b0, s_axis_tdata} >= n_eff)
                    begin
                        err_next   = plre_pkg::ST_RANGE;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        m_next         = n_eff - eidx_reg;
                        rank_req.cmd   = plre_pkg::RC_QUERY;
                        rank_req.value = s_axis_tdata;
                        div_start      = 1'b1;
                        state_next     = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!rank_sts.busy && !div_busy)
                begin
                    if (rank_sts.used)
                    begin
                        err_next   = plre_pkg::ST_REUSED;
                        state_next = S_ERR;
                    end
                    else if (m_reg > 17'd1)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full[31:0];
                range_next = div_quo;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                low_next   = 33'(low_reg + {1'b0, prod_reg});
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (range_reg < plre_pkg::RANGE_MIN)
                begin
                    if (do_shift)
                    begin
                        range_next = {range_reg[23:0], 8'h00};
                        low_next   = sh_low;
                        cache_next = sh_cache;
                        pend_next  = sh_pend;
                        if (sh_emit)
                        begin
                            if (hold_valid_reg)
                            begin
                                out_next       = hold_reg;
                                out_last_next  = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            hold_next       = sh_res;
                            hold_valid_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                rank_req.cmd = plre_pkg::RC_UPDATE;
                state_next   = S_UPDW;
            end
            S_UPDW:
            begin
                if (!rank_sts.busy)
                begin
                    eidx_next  = eidx_reg + 17'd1;
                    state_next = S_FIN;
                end
            end
            S_FLUSH:
            begin
                if (fcnt_reg == plre_pkg::FLUSH_SHIFTS)
                begin
                    state_next = S_FIN;
                end
                else if (do_shift)
                begin
                    fcnt_next  = fcnt_reg + 3'd1;
                    low_next   = sh_low;
                    cache_next = sh_cache;
                    pend_next  = sh_pend;
                    if (sh_emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = sh_res;
                        hold_valid_next = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next        = hold_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        hold_valid_next = 1'b0;
                    end
                    if (flush_reg)
                    begin
                        flush_next   = 1'b0;
                        eidx_next    = '0;
                        low_next     = '0;
                        range_next   = plre_pkg::RANGE_INIT;
                        cache_next   = '0;
                        pend_next    = 32'd1;
                        rank_req.cmd = plre_pkg::RC_CLEAR;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_next.status   = err_reg;
                    out_next.head     = '0;
                    out_next.run_len  = '0;
                    out_next.run_byte = '0;
                    out_last_next     = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_reg       <= 17'h10000;
            eidx_reg       <= '0;
            low_reg        <= '0;
            range_reg      <= plre_pkg::RANGE_INIT;
            cache_reg      <= '0;
            pend_reg       <= 32'd1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            flush_reg      <= 1'b0;
            fcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            eidx_reg       <= eidx_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            cache_reg      <= cache_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            flush_reg      <= flush_next;
            fcnt_reg       <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        err_reg      <= err_next;
        m_reg        <= m_next;
        val_reg      <= val_next;
        prod_reg     <= prod_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.run_byte, out_reg.run_len, out_reg.head};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_last_reg;

    // a finished item leaves nothing behind in the hold stage
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("hold stage occupied while idle");

    // the coder range is normalized between items
    a_idle_range_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (range_reg >= plre_pkg::RANGE_MIN))
        else $error("range not normalized while idle");

    // commands only reach the set while it is free
    a_rank_cmd_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_req.cmd != plre_pkg::RC_NONE) |-> !rank_sts.busy)
        else $error("set command issued while busy");

    // an error item never carries coded bytes with it
    a_err_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |-> !hold_valid_reg)
        else $error("error item with pending bytes");

endmodule

[tb/sv/permutation_lehmer_range_encoder_tb.sv]
// testbench for the permutation lehmer range encoder: directed and random permutations
module permutation_lehmer_range_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NVALS = 65536;
    localparam int unsigned STALL_LIMIT = 200000;

    typedef struct {
        plre_pkg::status_t status;
        logic [7:0]        head;
        logic [31:0]       run_len;
        logic [7:0]        run_byte;
        logic              last;
    } byte_run_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // elem_value
    logic [0:0]  s_axis_tuser;    // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // head_byte, run_length, run_byte
    logic [1:0]  m_axis_tuser;    // status
    logic        m_axis_tlast;

    // encoder mirror state
    bit          used_map [NVALS];
    logic [16:0] perm_n_reg;
    logic [16:0] elem_idx;
    logic [32:0] enc_low;
    logic [31:0] enc_range;
    logic [7:0]  enc_cache;
    logic [31:0] enc_pending;

    byte_run_t   expected_runs[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          runs_checked = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    permutation_lehmer_range_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [16:0] perm_len();
        if (perm_n_reg == 17'd0)
            return 17'd1;
        if (perm_n_reg > 17'd65536)
            return 17'd65536;
        return perm_n_reg;
    endfunction

    task automatic clear_encoder();
        foreach (used_map[v])
            used_map[v] = 1'b0;
        elem_idx    = '0;
        enc_low     = '0;
        enc_range   = plre_pkg::RANGE_INIT;
        enc_cache   = '0;
        enc_pending = 32'd1;
    endtask

    task automatic add_run(plre_pkg::status_t st, logic [7:0] hd, logic [31:0] rl,
                           logic [7:0] rb);
        byte_run_t r;
        r.status   = st;
        r.head     = hd;
        r.run_len  = rl;
        r.run_byte = rb;
        r.last     = 1'b0;
        expected_runs.insert(expected_runs.size(), r);
    endtask

    task automatic shift_out_byte(inout int emitted);
        logic        carry;
        logic [31:0] lo;
        carry = enc_low[32];
        lo    = enc_low[31:0];
        if (carry || lo < plre_pkg::LOW_TOP)
        begin
            add_run(plre_pkg::ST_RUN, 8'(enc_cache + {7'd0, carry}), enc_pending - 32'd1,
                    8'(plre_pkg::BYTE_FF + {7'd0, carry}));
            emitted++;
            enc_cache   = lo[31:24];
            enc_pending = 32'd1;
        end
        else if (enc_pending != plre_pkg::PEND_MAX)
        begin
            enc_pending++;
        end
        enc_low = {1'b0, lo[23:0], 8'h00};
    endtask

    // work out the byte runs one accepted item causes
    task automatic predict_runs(plre_pkg::act_t act, logic [15:0] v);
        int          emitted;
        logic [16:0] n;
        logic [16:0] left;
        logic [31:0] rank;
        emitted = 0;
        n = perm_len();
        if (act == plre_pkg::ACT_FLUSH)
        begin
            repeat (5)
                shift_out_byte(emitted);
            clear_encoder();
        end
        else if (elem_idx >= n)
        begin
            add_run(plre_pkg::ST_SURPLUS, 8'd0, 32'd0, 8'd0);
            emitted = 1;
        end
        else if ({1'b0, v} >= n)
        begin
            add_run(plre_pkg::ST_RANGE, 8'd0, 32'd0, 8'd0);
            emitted = 1;
        end
        else if (used_map[v])
        begin
            add_run(plre_pkg::ST_REUSED, 8'd0, 32'd0, 8'd0);
            emitted = 1;
        end
        else
        begin
            left = n - elem_idx;
            if (left > 17'd1)
            begin
                rank = 0;
                for (int k = 0; k < int'(v); k++)
                    if (!used_map[k])
                        rank++;
                enc_range = enc_range / {15'd0, left};
                enc_low   = enc_low + 33'(64'(rank) * 64'(enc_range));
                while (enc_range < plre_pkg::RANGE_MIN)
                begin
                    enc_range = enc_range << 8;
                    shift_out_byte(emitted);
                end
            end
            used_map[v] = 1'b1;
            elem_idx++;
        end
        if (emitted > 0)
            expected_runs[$].last = 1'b1;
    endtask

    // drop valid between items
    task automatic release_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_item(plre_pkg::act_t act, logic [15:0] v);
        // random short waits before most items and bursts with none
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_runs(act, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (expected_runs.size() != 0 && !timed_out)
            @(posedge clk);
        // elements that emit nothing may still be in flight
        repeat (120) @(posedge clk);
    endtask

    task automatic write_perm_size(logic [16:0] val);
        release_input();
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        perm_n_reg = val;
    endtask

    // a whole permutation of size n in random order, optionally cut short
    task automatic send_permutation(int n, int count);
        int order[$];
        int j;
        int t;
        for (int k = 0; k < n; k++)
            order.insert(order.size(), k);
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < count && k < n; k++)
            send_item(plre_pkg::ACT_CODE, 16'(order[k]));
    endtask

    task automatic test_small_perms();
        write_perm_size(17'd1);
        send_item(plre_pkg::ACT_CODE, 16'd0);
        send_item(plre_pkg::ACT_CODE, 16'd0);
        send_item(plre_pkg::ACT_CODE, 16'hFFFF);
        send_item(plre_pkg::ACT_FLUSH, 16'd0);
        write_perm_size(17'd0);
        send_item(plre_pkg::ACT_CODE, 16'd0);
        send_item(plre_pkg::ACT_FLUSH, 16'hFFFF);
        write_perm_size(17'd4);
        send_item(plre_pkg::ACT_CODE, 16'd3);
        send_item(plre_pkg::ACT_CODE, 16'd3);
        send_item(plre_pkg::ACT_CODE, 16'd4);
        send_item(plre_pkg::ACT_CODE, 16'd0);
        send_item(plre_pkg::ACT_CODE, 16'd2);
        send_item(plre_pkg::ACT_CODE, 16'd1);
        send_item(plre_pkg::ACT_CODE, 16'd1);
        send_item(plre_pkg::ACT_FLUSH, 16'd0);
    endtask

    task automatic test_extreme_sizes();
        write_perm_size(17'h1FFFF);
        send_item(plre_pkg::ACT_CODE, 16'hFFFF);
        send_item(plre_pkg::ACT_CODE, 16'h0000);
        send_item(plre_pkg::ACT_CODE, 16'h5555);
        send_item(plre_pkg::ACT_CODE, 16'hAAAA);
        // shrinking n mid-permutation makes it full at once
        write_perm_size(17'd3);
        send_item(plre_pkg::ACT_CODE, 16'd1);
        send_item(plre_pkg::ACT_CODE, 16'd2);
        send_item(plre_pkg::ACT_FLUSH, 16'd0);
        write_perm_size(17'd65536);
        send_item(plre_pkg::ACT_CODE, 16'd40000);
        send_item(plre_pkg::ACT_FLUSH, 16'd0);
    endtask

    task automatic test_random_perms();
        int n;
        while (items_sent < 400 && !timed_out)
        begin
            case ($urandom_range(0, 5))
                0:       n = $urandom_range(2, 5);
                1:       n = $urandom_range(200, 65536);
                default: n = $urandom_range(6, 40);
            endcase
            write_perm_size(17'(n));
            send_permutation(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 40);
            repeat ($urandom_range(0, 3))
            begin
                // noise: random values, possibly reused or out of range
                send_item(plre_pkg::ACT_CODE, 16'($urandom_range(0, 65535)));
            end
            send_item(plre_pkg::ACT_FLUSH, 16'($urandom_range(0, 65535)));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        byte_run_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            runs_checked++;
            if (expected_runs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected byte run: status %0d data %h", m_axis_tuser,
                        m_axis_tdata);
            end
            else
            begin
                e = expected_runs.pop_front();
                if (m_axis_tuser !== e.status || m_axis_tdata[7:0] !== e.head ||
                    m_axis_tdata[39:8] !== e.run_len || m_axis_tdata[47:40] !== e.run_byte ||
                    m_axis_tlast !== e.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("byte run mismatch: exp st %0d hd %h rl %0d rb %h last %b",
                            e.status, e.head, e.run_len, e.run_byte, e.last);
                        $display("    got st %0d hd %h rl %0d rb %h last %b",
                            m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                            m_axis_tdata[47:40], m_axis_tlast);
                    end
                end
            end
        end
    end

    // output stall pattern
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // watchdog: covers the clearing pass after reset or flush
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("permutation_lehmer_range_encoder regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        perm_n_reg     = 17'd65536;
        clear_encoder();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_perms();
        test_extreme_sizes();
        test_random_perms();
        release_input();
        wait_drained();

        $display("coded %0d items (elements and flushes) and checked %0d byte runs",
            items_sent, runs_checked);
        $display("sizes from 0 to the maximum, errors, early flushes and mid-run resizing");
        if (mismatch_count == 0 && expected_runs.size() == 0)
            $display("permutation_lehmer_range_encoder regression: pass");
        else
            $display("permutation_lehmer_range_encoder regression: fail");
        $finish;
    end

endmodule
